@@ design/tap_burst_confirmer_core_macros.svh @@
// Assertion macros shared by the tap burst confirmer modules.
`ifndef TAP_BURST_CONFIRMER_CORE_MACROS_SVH
`define TAP_BURST_CONFIRMER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TBC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tap burst confirmer check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TBC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tap burst confirmer check failed");

`else

`define TBC_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define TBC_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

@@ design/tbc_pkg.sv @@
// Types, constants and helper functions of the tap burst confirmer.
package tbc_pkg;

    localparam int BASE_SAMPLES = 16;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [2:0]  TAPS_INIT   = 3'd1;
    localparam logic [2:0]  TAPS_SAT    = 3'd7;
    localparam logic [15:0] MS_SAT      = 16'hFFFF;

    localparam logic [15:0] WINDOW_MS_RST   = 16'd1500;
    localparam logic [15:0] MIN_SEP_MS_RST  = 16'd70;
    localparam logic [11:0] DROP_THR_RST    = 12'd50;
    localparam logic [2:0]  MIN_TAPS_RST    = 3'd1;
    localparam logic [2:0]  MAX_TAPS_RST    = 3'd3;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_BASE = 3'b010,
        PH_WIN  = 3'b100
    } phase_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WINDOW_MS = 3'd0,
        CFG_MIN_SEP   = 3'd1,
        CFG_DROP_THR  = 3'd2,
        CFG_MIN_TAPS  = 3'd3,
        CFG_MAX_TAPS  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] window_ms;
        logic [15:0] min_separation_ms;
        logic [11:0] analog_drop_threshold;
        logic [2:0]  min_taps;
        logic [2:0]  max_taps;
    } cfg_t;

    typedef struct packed {
        logic        ms_tick;
        logic        digital_level;
        logic [11:0] analog_sample;
        logic        start_req;
    } item_t;

    typedef struct packed {
        logic        done_res;
        logic        confirmed;
        logic [2:0]  tap_count;
        logic        busy_res;
    } result_t;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == MS_SAT) ? MS_SAT : v + 16'd1;
    endfunction

endpackage

@@ design/tbc_cfg.sv @@
// Configuration register file of the tap burst confirmer.
module tbc_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tbc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tbc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output tbc_pkg::cfg_t                    cfg
);
    import tbc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WINDOW_MS: cfg_next.window_ms             = cfg_data;
                CFG_MIN_SEP:   cfg_next.min_separation_ms     = cfg_data;
                CFG_DROP_THR:  cfg_next.analog_drop_threshold = cfg_data[11:0];
                CFG_MIN_TAPS:  cfg_next.min_taps              = cfg_data[2:0];
                CFG_MAX_TAPS:  cfg_next.max_taps              = cfg_data[2:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_ms             <= WINDOW_MS_RST;
            cfg_reg.min_separation_ms     <= MIN_SEP_MS_RST;
            cfg_reg.analog_drop_threshold <= DROP_THR_RST;
            cfg_reg.min_taps              <= MIN_TAPS_RST;
            cfg_reg.max_taps              <= MAX_TAPS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/tbc_engine.sv @@
// Confirmation state and the per-beat step logic of the tap burst confirmer.
`include "tap_burst_confirmer_core_macros.svh"

module tbc_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  tbc_pkg::item_t    item,
    input  tbc_pkg::cfg_t     cfg,
    output tbc_pkg::result_t  result
);
    import tbc_pkg::*;

    phase_t      phase_reg,          phase_next;
    logic [4:0]  baseline_count_reg, baseline_count_next;
    logic [15:0] baseline_sum_reg,   baseline_sum_next;
    logic [11:0] rest_baseline_reg,  rest_baseline_next;
    logic        previous_level_reg, previous_level_next;
    logic [15:0] window_elapsed_reg, window_elapsed_next;
    logic [15:0] since_last_tap_reg, since_last_tap_next;
    logic [2:0]  taps_reg,           taps_next;

    always_comb
    begin
        logic done;
        logic conf;
        logic fall;
        logic drop;

        done = 1'b0;
        conf = 1'b0;
        fall = 1'b0;
        drop = 1'b0;

        phase_next          = phase_reg;
        baseline_count_next = baseline_count_reg;
        baseline_sum_next   = baseline_sum_reg;
        rest_baseline_next  = rest_baseline_reg;
        previous_level_next = previous_level_reg;
        window_elapsed_next = window_elapsed_reg;
        since_last_tap_next = since_last_tap_reg;
        taps_next           = taps_reg;

        if (item.start_req)
        begin
            phase_next          = PH_BASE;
            baseline_count_next = 5'd0;
            baseline_sum_next   = 16'd0;
            rest_baseline_next  = 12'd0;
            previous_level_next = 1'b1;
            window_elapsed_next = 16'd0;
            since_last_tap_next = 16'd0;
            taps_next           = TAPS_INIT;
        end

        unique case (phase_next)
            PH_BASE:
            begin
                baseline_sum_next   = baseline_sum_next + {4'd0, item.analog_sample};
                baseline_count_next = baseline_count_next + 5'd1;
                if (baseline_count_next >= 5'(BASE_SAMPLES))
                begin
                    rest_baseline_next  = 12'(baseline_sum_next / 16'(BASE_SAMPLES));
                    previous_level_next = item.digital_level;
                    window_elapsed_next = 16'd0;
                    since_last_tap_next = 16'd0;
                    taps_next           = TAPS_INIT;
                    phase_next          = PH_WIN;
                end
            end
            PH_WIN:
            begin
                if (item.ms_tick)
                begin
                    window_elapsed_next = sat_inc16(window_elapsed_next);
                    since_last_tap_next = sat_inc16(since_last_tap_next);
                end
                if (window_elapsed_next >= cfg.window_ms)
                begin
                    done = 1'b1;
                end
                else
                begin
                    fall = previous_level_next && !item.digital_level;
                    drop = (rest_baseline_next > item.analog_sample) &&
                           ((rest_baseline_next - item.analog_sample) >=
                            cfg.analog_drop_threshold);
                    if ((fall || drop) && (since_last_tap_next >= cfg.min_separation_ms))
                    begin
                        if (taps_next < TAPS_SAT)
                        begin
                            taps_next = taps_next + 3'd1;
                        end
                        since_last_tap_next = 16'd0;
                    end
                    previous_level_next = item.digital_level;
                    if (taps_next >= cfg.max_taps)
                    begin
                        done = 1'b1;
                    end
                end
                if (done)
                begin
                    conf = (taps_next >= cfg.min_taps) && (taps_next <= cfg.max_taps);
                    phase_next = PH_IDLE;
                end
            end
            PH_IDLE:
            begin
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        result.done_res  = done;
        result.confirmed = conf;
        result.tap_count = taps_next;
        result.busy_res  = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            baseline_count_reg <= 5'd0;
            baseline_sum_reg   <= 16'd0;
            rest_baseline_reg  <= 12'd0;
            previous_level_reg <= 1'b1;
            window_elapsed_reg <= 16'd0;
            since_last_tap_reg <= 16'd0;
            taps_reg           <= TAPS_INIT;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            baseline_count_reg <= baseline_count_next;
            baseline_sum_reg   <= baseline_sum_next;
            rest_baseline_reg  <= rest_baseline_next;
            previous_level_reg <= previous_level_next;
            window_elapsed_reg <= window_elapsed_next;
            since_last_tap_reg <= since_last_tap_next;
            taps_reg           <= taps_next;
        end
    end

    `TBC_ASSERT_IMP(a_taps_nonzero, clk, rst_n, 1'b1, taps_reg != 3'd0)
    `TBC_ASSERT_IMP(a_base_count_range, clk, rst_n, phase_reg == PH_BASE,
                    baseline_count_reg < 5'(BASE_SAMPLES))
    `TBC_ASSERT_IMP(a_phase_onehot, clk, rst_n, 1'b1, $onehot(phase_reg))

endmodule

@@ design/tap_burst_confirmer_core.sv @@
// Top level of the tap burst confirmer: input register, step engine, result register.

// The block takes one sensor beat per clock cycle while the output is not stalled and
// returns one result beat for each, through the input register and the result register.
// A beat with start_req set opens a confirmation: it and the following beats, sixteen
// in all, form the rest baseline, after which the counting window runs on ms_tick until
// it expires or the tap count reaches max_taps. The result beat that closes the window
// has m_tlast set and carries the confirmed flag. The user must write configuration
// through cfg_we, cfg_index and cfg_data while the stream is idle; the block never checks.
`include "tap_burst_confirmer_core_macros.svh"

module tap_burst_confirmer_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: start_req, analog_sample[11:0], digital_level, ms_tick, zero pad.
    input  logic [tbc_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0: confirmed, tap_count[2:0], busy_res, zero pad.
    output logic [tbc_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [tbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tbc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tbc_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg, in_valid_next;
    result_t step_result;
    result_t out_result_reg;
    logic    out_valid_reg, out_valid_next;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= item_t'(s_tdata[$bits(item_t)-1:0]);
        end
        if (advance)
        begin
            out_result_reg <= step_result;
        end
    end

    tbc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tbc_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_result_reg.done_res;
    assign m_tdata  = {3'd0, out_result_reg.busy_res, out_result_reg.tap_count,
                       out_result_reg.confirmed};

    `TBC_ASSERT_IMP(a_done_not_busy, clk, rst_n, m_tvalid && m_tlast, !m_tdata[4])
    `TBC_ASSERT_IMP(a_conf_needs_done, clk, rst_n, m_tvalid && m_tdata[0], m_tlast)
    `TBC_ASSERT_NXT(a_advance_fills_out, clk, rst_n, advance, out_valid_reg)

endmodule

@@ tb/tap_burst_checker.sv @@
// Checker for the tap burst confirmer: predicts each result beat and compares it field by field.
module tap_burst_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [tbc_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [tbc_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [tbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tbc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                fail_count,
    output int                                pending
);
    import tbc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic       done;
        logic       confirmed;
        logic [2:0] taps;
        logic       busy;
    } tap_outcome_t;

    tap_outcome_t outcome_q[$];
    int           results_seen;

    logic [15:0]  win_len_ms;
    logic [15:0]  sep_ms;
    logic [11:0]  drop_thr;
    logic [2:0]   taps_lo;
    logic [2:0]   taps_hi;

    phase_t       stage;
    logic [4:0]   base_n;
    logic [15:0]  base_acc;
    logic [11:0]  rest_lvl;
    logic         last_level;
    logic [15:0]  win_ms;
    logic [15:0]  gap_ms;
    logic [2:0]   tap_cnt;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < 100)
            $display("%0t: result %0d: %s got %0h want %0h", $realtime, results_seen, what, got,
                     want);
        fail_count++;
    endtask

    task automatic load_register(input logic [CFG_INDEX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] value);
        case (cfg_index_t'(idx))
            CFG_WINDOW_MS: win_len_ms = value;
            CFG_MIN_SEP:   sep_ms = value;
            CFG_DROP_THR:  drop_thr = value[11:0];
            CFG_MIN_TAPS:  taps_lo = value[2:0];
            CFG_MAX_TAPS:  taps_hi = value[2:0];
            default: ;
        endcase
    endtask

    task automatic judge_sample(input item_t it);
        tap_outcome_t o;
        logic         fall;
        logic         drop;
        o.done = 1'b0;
        o.confirmed = 1'b0;
        if (it.start_req)
        begin
            stage = PH_BASE;
            base_n = '0;
            base_acc = '0;
            rest_lvl = '0;
            last_level = 1'b1;
            win_ms = '0;
            gap_ms = '0;
            tap_cnt = TAPS_INIT;
        end
        if (stage == PH_BASE)
        begin
            base_acc = base_acc + 16'(it.analog_sample);
            base_n = base_n + 5'd1;
            if (base_n >= BASE_SAMPLES)
            begin
                rest_lvl = 12'(base_acc / BASE_SAMPLES);
                last_level = it.digital_level;
                win_ms = '0;
                gap_ms = '0;
                tap_cnt = TAPS_INIT;
                stage = PH_WIN;
            end
        end
        else if (stage == PH_WIN)
        begin
            if (it.ms_tick)
            begin
                if (win_ms != MS_SAT)
                    win_ms = win_ms + 16'd1;
                if (gap_ms != MS_SAT)
                    gap_ms = gap_ms + 16'd1;
            end
            if (win_ms >= win_len_ms)
                o.done = 1'b1;
            else
            begin
                fall = last_level && !it.digital_level;
                drop = (rest_lvl > it.analog_sample) &&
                       ((rest_lvl - it.analog_sample) >= drop_thr);
                if ((fall || drop) && gap_ms >= sep_ms)
                begin
                    if (tap_cnt != TAPS_SAT)
                        tap_cnt = tap_cnt + 3'd1;
                    gap_ms = '0;
                end
                last_level = it.digital_level;
                if (tap_cnt >= taps_hi)
                    o.done = 1'b1;
            end
            if (o.done)
            begin
                o.confirmed = (tap_cnt >= taps_lo) && (tap_cnt <= taps_hi);
                stage = PH_IDLE;
            end
        end
        o.taps = tap_cnt;
        o.busy = (stage != PH_IDLE);
        outcome_q.push_back(o);
    endtask

    task automatic check_result();
        tap_outcome_t w;
        results_seen++;
        if (outcome_q.size() == 0)
        begin
            report_mismatch("result beat with nothing expected", m_tdata, 0);
            return;
        end
        w = outcome_q.pop_front();
        if (m_tlast !== w.done)
            report_mismatch("done_res on tlast", m_tlast, w.done);
        if (m_tdata[0] !== w.confirmed)
            report_mismatch("confirmed", m_tdata[0], w.confirmed);
        if (m_tdata[3:1] !== w.taps)
            report_mismatch("tap_count", m_tdata[3:1], w.taps);
        if (m_tdata[4] !== w.busy)
            report_mismatch("busy_res", m_tdata[4], w.busy);
        if (m_tdata[OUT_TDATA_W-1:5] !== '0)
            report_mismatch("tdata padding", m_tdata[OUT_TDATA_W-1:5], 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_ms = WINDOW_MS_RST;
            sep_ms = MIN_SEP_MS_RST;
            drop_thr = DROP_THR_RST;
            taps_lo = MIN_TAPS_RST;
            taps_hi = MAX_TAPS_RST;
            stage = PH_IDLE;
            base_n = '0;
            base_acc = '0;
            rest_lvl = '0;
            last_level = 1'b1;
            win_ms = '0;
            gap_ms = '0;
            tap_cnt = TAPS_INIT;
            outcome_q.delete();
        end
        else
        begin
            if (cfg_we)
                load_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                judge_sample(item_t'(s_tdata[$bits(item_t)-1:0]));
            if (m_tvalid && m_tready)
                check_result();
        end
        pending = outcome_q.size();
    end

endmodule

@@ tb/tb.sv @@
// Testbench top for the tap burst confirmer: clock, reset, configuration and sensor beats.
module tb;
    import tbc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES     = 12;
    localparam int PHASE_ITEMS = 150;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_TDATA_W-1:0]    s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_TDATA_W-1:0]   m_tdata;
    logic                     m_tlast;
    logic                     cfg_we;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    int fail_count;
    int pending;
    int items_sent;
    bit src_idle_on;
    bit sink_idle_on;

    tap_burst_confirmer_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    tap_burst_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && sink_idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 16);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic item_t make_item(input logic start, input logic [11:0] a,
                                        input logic lvl, input logic tick);
        item_t it;
        it.start_req = start;
        it.analog_sample = a;
        it.digital_level = lvl;
        it.ms_tick = tick;
        return it;
    endfunction

    function automatic logic [11:0] near(input logic [11:0] center, input int spread);
        int v;
        v = int'(center) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[11:0];
    endfunction

    task automatic send_beat(input item_t it);
        int gap;
        @(negedge clk);
        if (src_idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_TDATA_W - $bits(item_t)){1'b0}}, it};
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic drain_stream();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] w, input logic [15:0] sep,
                              input logic [11:0] thr, input logic [2:0] lo,
                              input logic [2:0] hi);
        write_reg(CFG_WINDOW_MS, w);
        write_reg(CFG_MIN_SEP, sep);
        write_reg(CFG_DROP_THR, {4'd0, thr});
        write_reg(CFG_MIN_TAPS, {13'd0, lo});
        write_reg(CFG_MAX_TAPS, {13'd0, hi});
    endtask

    task automatic send_noise();
        logic [14:0] raw;
        raw = 15'($urandom);
        raw[0] = ($urandom_range(0, 7) == 0);
        send_beat(item_t'(raw));
    endtask

    // A start beat, the baseline beats around a rest level, then window beats with
    // level flips and occasional analog drops. Some baselines are cut short so that
    // the following start lands while the block is still busy.
    task automatic send_confirmation();
        logic [11:0] rest;
        logic [11:0] a;
        logic        lvl;
        int          spread;
        int          base_len;
        int          win_len;
        int          k;
        rest = 12'($urandom_range(0, 4095));
        spread = $urandom_range(0, 40);
        base_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, BASE_SAMPLES - 1)
                                               : BASE_SAMPLES;
        win_len = $urandom_range(0, 50);
        lvl = ($urandom_range(0, 3) != 0);
        send_beat(make_item(1'b1, near(rest, spread), lvl, 1'($urandom_range(0, 1))));
        for (k = 1; k < base_len; k++)
            send_beat(make_item(1'b0, near(rest, spread), $urandom_range(0, 7) != 0,
                                1'($urandom_range(0, 1))));
        if (base_len < BASE_SAMPLES)
            return;
        for (k = 0; k < win_len; k++)
        begin
            if ($urandom_range(0, 3) == 0)
                lvl = ~lvl;
            a = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095)) : near(rest, spread);
            send_beat(make_item(1'b0, a, lvl, $urandom_range(0, 2) != 0));
        end
    endtask

    initial
    begin
        int          p;
        int          k;
        int          goal;
        logic [15:0] w;
        logic [15:0] sep;
        logic [11:0] thr;
        logic [2:0]  lo;
        logic [2:0]  hi;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        items_sent = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: ignored beats while idle, a restart during the baseline, a baseline
        // of 3839, a drop of one below baseline with zero threshold, a level fall, expiry.
        set_config(16'd4, 16'd0, 12'd0, 3'd0, 3'd7);
        send_beat(make_item(1'b0, 12'hFFF, 1'b1, 1'b1));
        send_beat(make_item(1'b0, 12'h000, 1'b0, 1'b0));
        send_beat(make_item(1'b1, 12'hFFF, 1'b1, 1'b1));
        send_beat(make_item(1'b0, 12'hFFF, 1'b0, 1'b1));
        send_beat(make_item(1'b0, 12'hFFF, 1'b1, 1'b0));
        send_beat(make_item(1'b1, 12'hFFF, 1'b1, 1'b1));
        for (k = 1; k < BASE_SAMPLES - 1; k++)
            send_beat(make_item(1'b0, 12'hFFF, k[0], k[1]));
        send_beat(make_item(1'b0, 12'h000, 1'b1, 1'b0));
        send_beat(make_item(1'b0, 12'd3839, 1'b1, 1'b0));
        send_beat(make_item(1'b0, 12'd3838, 1'b1, 1'b1));
        send_beat(make_item(1'b0, 12'hFFF, 1'b0, 1'b1));
        send_beat(make_item(1'b0, 12'hFFF, 1'b1, 1'b1));
        send_beat(make_item(1'b0, 12'hFFF, 1'b1, 1'b1));
        drain_stream();

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: set_config(16'hFFFF, 16'hFFFF, 12'hFFF, 3'd7, 3'd7);
                1: set_config(16'd0, 16'd0, 12'd0, 3'd0, 3'd0);
                2: set_config(16'd1, 16'd0, 12'd0, 3'd0, 3'd1);
                default:
                begin
                    w = 16'($urandom_range(2, 40));
                    sep = 16'($urandom_range(0, 6));
                    thr = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                                      : 12'($urandom_range(0, 200));
                    lo = 3'($urandom_range(0, 7));
                    hi = 3'($urandom_range(0, 7));
                    set_config(w, sep, thr, lo, hi);
                end
            endcase
            src_idle_on = (p != PHASES - 1) && ($urandom_range(0, 2) != 0);
            sink_idle_on = (p != PHASES - 1) && ($urandom_range(0, 2) != 0);
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal)
            begin
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 4)) send_noise();
                else
                    send_confirmation();
            end
            drain_stream();
        end

        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
